@@ rtl/oaht_pkg.sv @@
`default_nettype none

package oaht_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int SIZE_W   = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 32;

  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic eval;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_err;
    logic probe_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/oaht_ctrl.sv @@
`default_nettype none

module oaht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output oaht_pkg::dp_cmd_t    cmd,
  input  oaht_pkg::dp_status_t stat
);
  import oaht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.range_err ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.probe_done ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/oaht_dpath.sv @@
`default_nettype none

module oaht_dpath #(
  parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = oaht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = oaht_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  oaht_pkg::dp_cmd_t              cmd,
  output oaht_pkg::dp_status_t           stat,
  input  logic                           cfg_wr_en,
  input  logic [oaht_pkg::SIZE_W-1:0]    cfg_wr_data,
  input  logic [oaht_pkg::KIND_W-1:0]    kind,
  input  logic [oaht_pkg::KEY_W-1:0]     key,
  input  logic [oaht_pkg::VALUE_W-1:0]   value,
  input  logic [oaht_pkg::INDEX_W-1:0]   start_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [oaht_pkg::STATUS_W-1:0]  status,
  output logic                           hit,
  output logic [oaht_pkg::VALUE_W-1:0]   found_value,
  output logic [oaht_pkg::SLOT_W-1:0]    slot
);
  import oaht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam bit DEPTH_LIMITS = (TABLE_DEPTH < (1 << SIZE_W));
  localparam logic [SIZE_W-1:0] DEPTH_CAP = DEPTH_LIMITS ? SIZE_W'(TABLE_DEPTH) : '1;
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  mark_t                 mark_mem    [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   key_mem     [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] payload_mem [TABLE_DEPTH];

  logic [SIZE_W-1:0]     table_size;
  logic [AW-1:0]         clr_cnt;

  logic [KIND_W-1:0]     req_kind;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [SIZE_W-1:0]     size_r;
  logic [SIZE_W-1:0]     pos;
  logic [SIZE_W-1:0]     step;
  logic [SIZE_W-1:0]     left;
  logic                  have_del;
  logic [SIZE_W-1:0]     del_pos;
  logic                  ok;
  logic [SIZE_W-1:0]     chosen;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] found_r;
  logic                  range_err;

  mark_t                 mark_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] payload_q;

  logic [SIZE_W-1:0]     eff_size;
  logic [AW-1:0]         pos_idx;
  logic [AW-1:0]         chosen_idx;
  logic                  is_empty;
  logic                  is_del;
  logic                  is_match;
  logic                  is_last;
  logic [SIZE_W:0]       pos_sum;
  logic [SIZE_W-1:0]     pos_adv;
  logic                  have_del_n;
  logic [SIZE_W-1:0]     del_pos_n;
  logic                  wr_add;
  logic                  wr_del;
  logic [STATUS_W-1:0]   status_next;

  always_comb begin
    eff_size   = (DEPTH_LIMITS && (table_size > DEPTH_CAP)) ? DEPTH_CAP : table_size;
    pos_idx    = AW'(pos);
    chosen_idx = AW'(chosen);
    is_empty   = (mark_q == MARK_EMPTY);
    is_del     = (mark_q == MARK_DELETED);
    is_match   = (mark_q == MARK_USED) && (key_q == req_key);
    is_last    = (left == SIZE_W'(1));
    pos_sum    = {1'b0, pos} + {1'b0, step};
    pos_adv    = (pos_sum >= {1'b0, size_r}) ? SIZE_W'(pos_sum - {1'b0, size_r})
                                             : SIZE_W'(pos_sum);
    have_del_n = have_del | is_del;
    del_pos_n  = (is_del && !have_del) ? pos : del_pos;
    wr_add     = cmd.finish && !range_err && (req_kind == KIND_ADD) && ok && !hit_r;
    wr_del     = cmd.finish && !range_err && (req_kind == KIND_DELETE) && ok && hit_r;
    if (range_err) begin
      status_next = STATUS_RANGE;
    end else if ((req_kind == KIND_ADD) && !ok) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_DONE;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_cnt == CLR_LAST);
    stat.range_err  = range_err;
    stat.probe_done = is_empty | is_match | is_last;
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= kind;
      req_key   <= KEY_BITS'(key);
      req_value <= VALUE_BITS'(value);
      size_r    <= eff_size;
      pos       <= SIZE_W'(start_index);
      step      <= (start_index == '0) ? SIZE_W'(1) : SIZE_W'(start_index);
      left      <= eff_size;
      have_del  <= 1'b0;
      del_pos   <= '0;
      ok        <= 1'b0;
      chosen    <= '0;
      hit_r     <= 1'b0;
      found_r   <= '0;
      range_err <= ({1'b0, start_index} >= eff_size);
    end else if (cmd.eval) begin
      if (is_empty) begin
        ok     <= 1'b1;
        chosen <= have_del ? del_pos : pos;
      end else if (is_match) begin
        ok      <= 1'b1;
        chosen  <= pos;
        hit_r   <= 1'b1;
        found_r <= payload_q;
      end else begin
        have_del <= have_del_n;
        del_pos  <= del_pos_n;
        pos      <= pos_adv;
        left     <= left - SIZE_W'(1);
        if (is_last) begin
          ok     <= have_del_n;
          chosen <= del_pos_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= status_next;
      hit         <= hit_r;
      found_value <= VALUE_W'(found_r);
      slot        <= ok ? SLOT_W'(chosen) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mark_mem[clr_cnt] <= MARK_EMPTY;
    end else if (wr_add) begin
      mark_mem[chosen_idx] <= MARK_USED;
    end else if (wr_del) begin
      mark_mem[chosen_idx] <= MARK_DELETED;
    end
    if (cmd.rd) begin
      mark_q <= mark_mem[pos_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_add) begin
      key_mem[chosen_idx] <= req_key;
    end
    if (cmd.rd) begin
      key_q <= key_mem[pos_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_add) begin
      payload_mem[chosen_idx] <= req_value;
    end
    if (cmd.rd) begin
      payload_q <= payload_mem[pos_idx];
    end
  end

endmodule

`default_nettype wire

@@ rtl/open_address_hash_table_top.sv @@
`default_nettype none

// Open-addressing key/value table with tombstones. Each transaction on the
// input channel is a find, add or delete with a precomputed start index; one
// result transaction comes back per request. After reset the slot marks are
// swept to empty, one slot per cycle, and no request is taken until the sweep
// ends. Each probe is a read state, which reads the slot memories, and then
// an evaluate state, which compares the key and steps the index; a request
// probes from one slot up to the table size. A start index out of range goes
// from the check state straight to the result, with no probe. The result sits
// in an output register, so the next request is accepted while it waits.
// Write table_size only while no request is in flight.
module open_address_hash_table_top #(
  parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = oaht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = oaht_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [oaht_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oaht_pkg::KIND_W-1:0]   kind,
  input  logic [oaht_pkg::KEY_W-1:0]    key,
  input  logic [oaht_pkg::VALUE_W-1:0]  value,
  input  logic [oaht_pkg::INDEX_W-1:0]  start_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oaht_pkg::STATUS_W-1:0] status,
  output logic                          hit,
  output logic [oaht_pkg::VALUE_W-1:0]  found_value,
  output logic [oaht_pkg::SLOT_W-1:0]   slot
);
  import oaht_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  oaht_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .start_index (start_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .found_value (found_value),
    .slot        (slot)
  );

endmodule

`default_nettype wire

@@ tb/sv/open_address_hash_table_top_tb.sv @@
`default_nettype none

module open_address_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int WATCHDOG = 5000;
  localparam int IDLE_PCT = 29;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_SIZE [NUM_PHASES] = '{16, 256, 7, 64, 1, 511, 2, 0, 32, 255, 3, 128};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 250, 120, 250, 40, 200, 60, 20, 200, 150,
                                              60, 50};
  localparam int CALM_PHASE = 3;
  localparam int POOL_MAX = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [VALUE_W-1:0]  found_value;
    logic [SLOT_W-1:0]   slot;
  } table_result_t;

  typedef struct packed {
    logic                cfg;
    logic [SIZE_W-1:0]   size;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  start;
    logic                typed;
    table_result_t       res;
  } dir_row_t;

  localparam int NUM_DIR = 25;
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b0, 9'd0, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b1, '{STATUS_DONE, 1'b0, 32'h0, 8'd0}},
    '{1'b0, 9'd0, KIND_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 1'b1,
      '{STATUS_DONE, 1'b0, 32'h0, 8'd255}},
    '{1'b0, 9'd0, KIND_FIND, 32'hFFFFFFFF, 32'h0, 8'd255, 1'b1,
      '{STATUS_DONE, 1'b1, 32'hFFFFFFFF, 8'd255}},
    '{1'b0, 9'd0, KIND_ADD, 32'hFFFFFFFF, 32'h0, 8'd255, 1'b1,
      '{STATUS_DONE, 1'b1, 32'hFFFFFFFF, 8'd255}},
    '{1'b0, 9'd0, KIND_DELETE, 32'hFFFFFFFF, 32'h0, 8'd255, 1'b1,
      '{STATUS_DONE, 1'b1, 32'hFFFFFFFF, 8'd255}},
    '{1'b0, 9'd0, KIND_FIND, 32'hFFFFFFFF, 32'h0, 8'd255, 1'b0, '0},
    '{1'b0, 9'd0, KIND_ADD, 32'h1, 32'h12345678, 8'd255, 1'b0, '0},
    '{1'b0, 9'd0, KIND_DELETE, 32'h2, 32'h0, 8'd3, 1'b0, '0},
    '{1'b0, 9'd0, KIND_SPARE, 32'h1, 32'hFFFFFFFF, 8'd255, 1'b0, '0},
    '{1'b0, 9'd0, KIND_ADD, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_ADD, 32'hA5A5A5A5, 32'h5A5A5A5A, 8'd0, 1'b0, '0},
    '{1'b1, 9'd511, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_FIND, 32'h1, 32'h0, 8'd255, 1'b0, '0},
    '{1'b1, 9'd0, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_FIND, 32'h1, 32'h0, 8'd0, 1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 8'd0}},
    '{1'b0, 9'd0, KIND_ADD, 32'h3, 32'h9, 8'd0, 1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 8'd0}},
    '{1'b1, 9'd2, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_ADD, 32'h10, 32'h77, 8'd0, 1'b1, '{STATUS_FULL, 1'b0, 32'h0, 8'd0}},
    '{1'b0, 9'd0, KIND_FIND, 32'h2, 32'h0, 8'd2, 1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 8'd0}},
    '{1'b0, 9'd0, KIND_DELETE, 32'h0, 32'h0, 8'd0, 1'b1, '{STATUS_DONE, 1'b1, 32'h0, 8'd0}},
    '{1'b0, 9'd0, KIND_ADD, 32'h10, 32'hFFFFFFFF, 8'd1, 1'b0, '0},
    '{1'b1, 9'd1, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_FIND, 32'h10, 32'h0, 8'd0, 1'b0, '0},
    '{1'b0, 9'd0, KIND_ADD, 32'h7, 32'h1, 8'd0, 1'b1, '{STATUS_FULL, 1'b0, 32'h0, 8'd0}},
    '{1'b1, 9'd256, KIND_FIND, 32'h0, 32'h0, 8'd0, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [SIZE_W-1:0]   cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;
  logic [INDEX_W-1:0]  start_index;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic [VALUE_W-1:0]  found_value;
  logic [SLOT_W-1:0]   slot;

  mark_t               slot_marks [DEPTH];
  logic [KEY_W-1:0]    slot_keys [DEPTH];
  logic [VALUE_W-1:0]  slot_values [DEPTH];
  logic [SIZE_W-1:0]   table_size_q;

  table_result_t       result_q [$];
  table_result_t       want;
  logic                calm;
  int                  errors = 0;
  int                  n_sent;
  int                  n_checked = 0;
  int                  n_hit = 0;
  int                  n_full = 0;
  int                  n_range = 0;
  int                  n_cfg;
  int                  idle_cycles = 0;

  open_address_hash_table_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .start_index (start_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .hit         (hit),
    .found_value (found_value),
    .slot        (slot)
  );

  always #5 clk = ~clk;

  function automatic table_result_t table_apply(logic [KIND_W-1:0] op, logic [KEY_W-1:0] k,
                                                logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] st);
    table_result_t r;
    int unsigned   sz;
    int unsigned   pos;
    int unsigned   step;
    int unsigned   left;
    int unsigned   del_pos;
    int unsigned   chosen;
    bit            have_del;
    bit            stop;
    bit            ok;
    r = '0;
    sz = (table_size_q > DEPTH) ? DEPTH : table_size_q;
    if (st >= sz) begin
      r.status = STATUS_RANGE;
      return r;
    end
    pos = st;
    step = (st != 0) ? st : 1;
    left = sz;
    have_del = 1'b0;
    del_pos = 0;
    stop = 1'b0;
    chosen = 0;
    while (left != 0 && !stop) begin
      if (slot_marks[pos] == MARK_EMPTY) begin
        chosen = have_del ? del_pos : pos;
        stop = 1'b1;
      end else if (slot_marks[pos] == MARK_DELETED) begin
        if (!have_del) begin
          have_del = 1'b1;
          del_pos = pos;
        end
      end else if (slot_keys[pos] == k) begin
        chosen = pos;
        stop = 1'b1;
      end
      if (!stop) begin
        left--;
        pos = (pos + step) % sz;
      end
    end
    ok = stop || have_del;
    if (!stop) chosen = del_pos;
    r.status = STATUS_DONE;
    if (ok) begin
      r.slot = SLOT_W'(chosen);
      if (slot_marks[chosen] == MARK_USED) begin
        r.hit = 1'b1;
        r.found_value = slot_values[chosen];
      end
    end
    if (op == KIND_ADD) begin
      if (!ok) begin
        r.status = STATUS_FULL;
      end else if (!r.hit) begin
        slot_marks[chosen] = MARK_USED;
        slot_keys[chosen] = k;
        slot_values[chosen] = v;
      end
    end else if (op == KIND_DELETE && ok && r.hit) begin
      slot_marks[chosen] = MARK_DELETED;
    end
    return r;
  endfunction

  function automatic logic [INDEX_W-1:0] home_slot(logic [KEY_W-1:0] k, int unsigned sz);
    logic [31:0] h;
    h = k * 32'h9E3779B1;
    h = h ^ (h >> 15);
    return INDEX_W'(h % sz);
  endfunction

  task automatic send_request(logic [KIND_W-1:0] op, logic [KEY_W-1:0] k,
                              logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] st,
                              logic typed, table_result_t typed_res);
    table_result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = op;
    key = k;
    value = v;
    start_index = st;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    r = table_apply(op, k, v, st);
    result_q.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  task automatic write_table_size(logic [SIZE_W-1:0] sz);
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = sz;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    table_size_q = sz;
    n_cfg++;
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got status %0d hit %0d value %h slot %0d",
                 $time, status, hit, found_value, slot);
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (hit) n_hit++;
        if (status == STATUS_FULL) n_full++;
        if (status == STATUS_RANGE) n_range++;
        if (status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
        end
        if (hit !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch: expected %0d, got %0d", $time, want.hit, hit);
        end
        if (found_value !== want.found_value) begin
          errors++;
          $display("%0t: found_value mismatch: expected %h, got %h", $time, want.found_value,
                   found_value);
        end
        if (slot !== want.slot) begin
          errors++;
          $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot, slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]   pool [POOL_MAX];
    int                 pool_n;
    int unsigned        eff;
    int                 pick;
    logic [KIND_W-1:0]  op;
    logic [KEY_W-1:0]   k;
    logic [INDEX_W-1:0] st;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    kind = '0;
    key = '0;
    value = '0;
    start_index = '0;
    calm = 1'b0;
    n_sent = 0;
    n_cfg = 0;
    table_size_q = SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      slot_marks[i] = MARK_EMPTY;
      slot_keys[i] = '0;
      slot_values[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TAB[i].cfg) begin
        write_table_size(DIR_TAB[i].size);
      end else begin
        send_request(DIR_TAB[i].kind, DIR_TAB[i].key, DIR_TAB[i].value, DIR_TAB[i].start,
                     DIR_TAB[i].typed, DIR_TAB[i].res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_table_size(SIZE_W'(PHASE_SIZE[p]));
      calm = (p == CALM_PHASE);
      eff = (PHASE_SIZE[p] > DEPTH) ? DEPTH : PHASE_SIZE[p];
      pool_n = (eff <= 16) ? eff + 2 : 24 + $urandom_range(40);
      for (int j = 0; j < pool_n; j++) pool[j] = $urandom;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (eff == 0 || $urandom_range(99) >= 85) begin
          op = KIND_W'($urandom_range(3));
          k = $urandom;
          st = INDEX_W'($urandom_range(255));
        end else begin
          k = pool[$urandom_range(pool_n - 1)];
          st = home_slot(k, eff);
          pick = $urandom_range(99);
          op = (pick < 45) ? KIND_ADD : (pick < 75) ? KIND_FIND :
               (pick < 95) ? KIND_DELETE : KIND_SPARE;
        end
        send_request(op, k, $urandom, st, 1'b0, '0);
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests, %0d results checked, %0d table size writes",
             n_sent, n_checked, n_cfg);
    $display("Results seen: %0d hits, %0d table full, %0d start index out of range",
             n_hit, n_full, n_range);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
